### design/tgi_pkg.sv
// tgi_pkg: shared types, codes and constants of the trilinear grid interpolator
// no dependencies
`default_nettype none
package tgi_pkg;

	localparam int GRID_X_DEF = 32;
	localparam int GRID_Y_DEF = 32;
	localparam int GRID_Z_DEF = 32;

	localparam int VAL_W     = 24;
	localparam int IDX_W     = 5;
	localparam int CMD_W     = 2;
	localparam int STS_W     = 2;
	localparam int WGT_W     = 16;
	localparam int DIV_BITS  = 16;
	localparam int CFG_IDX_W = 2;
	localparam int MUL_W     = 25;

	localparam logic [CMD_W-1:0] CMD_WRITE_SAMPLE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WRITE_BREAK  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY        = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NONE         = 2'd3;

	localparam logic [STS_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STS_W-1:0] STATUS_WRITTEN = 2'd1;
	localparam logic [STS_W-1:0] STATUS_OUTSIDE = 2'd2;
	localparam logic [STS_W-1:0] STATUS_Y_BOUND = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_X_STEP_INV = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_Z_STEP_INV = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_CHECK    = 2'd2;

	localparam logic [VAL_W-1:0] STEP_INV_RESET = 24'd65536;
	localparam logic signed [VAL_W-1:0] Q16_ONE       = 24'sd65536;
	localparam logic signed [VAL_W-1:0] Q16_MINUS_ONE = -24'sd65536;

	typedef struct packed {
		logic [CMD_W-1:0]        command;
		logic [IDX_W-1:0]        grid_x_index;
		logic [IDX_W-1:0]        grid_y_index;
		logic [IDX_W-1:0]        grid_z_index;
		logic signed [VAL_W-1:0] write_value;
		logic signed [VAL_W-1:0] coord_x;
		logic signed [VAL_W-1:0] coord_y;
		logic signed [VAL_W-1:0] coord_z;
	} in_item_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] interpolated_value;
		logic [STS_W-1:0]        status;
	} out_item_t;

	typedef struct packed {
		logic [VAL_W-1:0] x_step_inverse;
		logic [VAL_W-1:0] z_step_inverse;
		logic             y_bound_check;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_MULX,
		ST_MULZ,
		ST_CHKZ,
		ST_SRCH_START,
		ST_SRCH,
		ST_DIV_START,
		ST_DIV_WAIT,
		ST_CORNER,
		ST_BL_MUL,
		ST_BL_ADD,
		ST_DONE
	} core_state_t;

endpackage
`default_nettype wire

### design/tgi_divider.sv
// tgi_divider: restoring divider, one quotient bit per cycle
// numerator must be below denominator; depends on tgi_pkg
`default_nettype none
module tgi_divider (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [tgi_pkg::MUL_W-1:0]   num,
	input  wire logic [tgi_pkg::MUL_W-1:0]   den,
	output logic                             done,
	output logic [tgi_pkg::DIV_BITS-1:0]     quo
);
	localparam int CW = $clog2(tgi_pkg::DIV_BITS);

	logic                        busy_q;
	logic                        done_q;
	logic [CW-1:0]               cnt_q;
	logic [tgi_pkg::MUL_W-1:0]   rem_q;
	logic [tgi_pkg::MUL_W-1:0]   den_q;
	logic [tgi_pkg::DIV_BITS-1:0] quo_q;
	logic [tgi_pkg::MUL_W:0]     shifted;
	logic [tgi_pkg::MUL_W:0]     diff;
	logic                        ge;

	assign shifted = {rem_q, 1'b0};
	assign diff    = shifted - {1'b0, den_q};
	assign ge      = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(tgi_pkg::DIV_BITS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				done_q <= 1'b0;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[tgi_pkg::MUL_W-1:0] : shifted[tgi_pkg::MUL_W-1:0];
			quo_q <= {quo_q[tgi_pkg::DIV_BITS-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule
`default_nettype wire

### design/tgi_core.sv
// tgi_core: sample and breakpoint memories with the query sequencer
// depends on tgi_pkg and tgi_divider
`default_nettype none
module tgi_core #(
	parameter int GRID_X = tgi_pkg::GRID_X_DEF,
	parameter int GRID_Y = tgi_pkg::GRID_Y_DEF,
	parameter int GRID_Z = tgi_pkg::GRID_Z_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire tgi_pkg::in_item_t  in_data,
	input  wire tgi_pkg::cfg_t      cfg,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output tgi_pkg::out_item_t      res_data
);
	localparam int DEPTH = GRID_X * GRID_Y * GRID_Z;
	localparam int AW = $clog2(DEPTH);
	localparam int XW = $clog2(GRID_X);
	localparam int YW = $clog2(GRID_Y);
	localparam int ZW = $clog2(GRID_Z);
	localparam int VW = tgi_pkg::VAL_W;
	localparam int MW = tgi_pkg::MUL_W;
	localparam int PW = 2 * MW;

	function automatic logic [AW-1:0] grid_addr(input logic [XW-1:0] i,
			input logic [YW-1:0] j, input logic [ZW-1:0] k);
		return AW'((AW'(i) * AW'(GRID_Y) + AW'(j)) * AW'(GRID_Z) + AW'(k));
	endfunction

	tgi_pkg::core_state_t state_q, state_d;
	tgi_pkg::in_item_t    item_q;
	tgi_pkg::out_item_t   res_q;

	logic signed [VW-1:0] grid_mem [DEPTH];
	logic signed [VW-1:0] bp_mem [GRID_Y];
	logic signed [VW-1:0] g_rdata;
	logic signed [VW-1:0] bp_rdata;
	logic                 g_we, g_re, bp_we, bp_re;
	logic [AW-1:0]        g_addr;
	logic [YW-1:0]        bp_addr;

	logic signed [MW-1:0] mul_a, mul_b;
	logic signed [PW-1:0] product, prod_q;
	logic signed [VW-1:0] a_sel, b_sel, a_q;
	logic [tgi_pkg::WGT_W-1:0] w_sel;

	logic [XW-1:0]        i0_q;
	logic [ZW-1:0]        k0_q;
	logic [YW-1:0]        j_q;
	logic [tgi_pkg::WGT_W-1:0] xw_q, zw_q, yw_q;
	logic signed [VW-1:0] y0_q, y1_q;
	logic [3:0]           cnt_q;
	logic [2:0]           step_q;
	logic [AW-1:0]        addr_s1;
	logic signed [VW-1:0] corner_q [8];
	logic signed [VW-1:0] blend_q [7];

	logic                 accept;
	logic                 wr_sample_ok, wr_break_ok, y_out;
	logic signed [PW-33:0] cell_idx;
	logic                 cell_fail_x, cell_fail_z;
	logic                 y_lt;
	logic                 div_start, div_done;
	logic [MW-1:0]        div_num, div_den;
	logic [tgi_pkg::DIV_BITS-1:0] div_quo;
	logic signed [VW:0]   blend_sum;
	logic [2:0]           corner_n;
	logic [2:0]           corner_w;

	assign accept   = in_valid && (state_q == tgi_pkg::ST_IDLE);
	assign in_stall = (state_q != tgi_pkg::ST_IDLE);

	assign wr_sample_ok = (32'(item_q.grid_x_index) < GRID_X) &&
		(32'(item_q.grid_y_index) < GRID_Y) && (32'(item_q.grid_z_index) < GRID_Z);
	assign wr_break_ok  = 32'(item_q.grid_y_index) < GRID_Y;
	assign y_out = cfg.y_bound_check &&
		((item_q.coord_y < tgi_pkg::Q16_MINUS_ONE) || (item_q.coord_y > tgi_pkg::Q16_ONE));

	assign cell_idx = prod_q[PW-1:32];
	assign cell_fail_x = cell_idx[PW-33] || (cell_idx >= (PW-32)'(GRID_X - 1));
	assign cell_fail_z = cell_idx[PW-33] || (cell_idx >= (PW-32)'(GRID_Z - 1));
	assign y_lt = item_q.coord_y < bp_rdata;

	assign product   = mul_a * mul_b;
	assign blend_sum = {a_q[VW-1], a_q} + prod_q[VW+16:16];

	assign corner_n = cnt_q[2:0];
	assign corner_w = 3'(cnt_q - 4'd2);

	assign div_num = MW'({item_q.coord_y[VW-1], item_q.coord_y} - {y0_q[VW-1], y0_q});
	assign div_den = MW'({y1_q[VW-1], y1_q} - {y0_q[VW-1], y0_q});

	tgi_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk) begin
		if (g_we)
			grid_mem[g_addr] <= item_q.write_value;
		if (g_re)
			g_rdata <= grid_mem[g_addr];
	end

	always_ff @(posedge clk) begin
		if (bp_we)
			bp_mem[bp_addr] <= item_q.write_value;
		if (bp_re)
			bp_rdata <= bp_mem[bp_addr];
	end

	always_comb begin
		case (step_q)
			3'd0: begin a_sel = corner_q[0]; b_sel = corner_q[1]; w_sel = xw_q; end
			3'd1: begin a_sel = corner_q[2]; b_sel = corner_q[3]; w_sel = xw_q; end
			3'd2: begin a_sel = corner_q[4]; b_sel = corner_q[5]; w_sel = xw_q; end
			3'd3: begin a_sel = corner_q[6]; b_sel = corner_q[7]; w_sel = xw_q; end
			3'd4: begin a_sel = blend_q[0]; b_sel = blend_q[2]; w_sel = yw_q; end
			3'd5: begin a_sel = blend_q[1]; b_sel = blend_q[3]; w_sel = yw_q; end
			default: begin a_sel = blend_q[4]; b_sel = blend_q[5]; w_sel = zw_q; end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			tgi_pkg::ST_IDLE:
				if (accept)
					state_d = tgi_pkg::ST_DISPATCH;
			tgi_pkg::ST_DISPATCH:
				if (item_q.command == tgi_pkg::CMD_QUERY && !y_out)
					state_d = tgi_pkg::ST_MULX;
				else
					state_d = tgi_pkg::ST_DONE;
			tgi_pkg::ST_MULX:
				state_d = tgi_pkg::ST_MULZ;
			tgi_pkg::ST_MULZ:
				state_d = cell_fail_x ? tgi_pkg::ST_DONE : tgi_pkg::ST_CHKZ;
			tgi_pkg::ST_CHKZ:
				state_d = cell_fail_z ? tgi_pkg::ST_DONE : tgi_pkg::ST_SRCH_START;
			tgi_pkg::ST_SRCH_START:
				state_d = tgi_pkg::ST_SRCH;
			tgi_pkg::ST_SRCH:
				if (y_lt)
					state_d = (j_q == '0) ? tgi_pkg::ST_DONE : tgi_pkg::ST_DIV_START;
				else if (j_q == YW'(GRID_Y - 1))
					state_d = tgi_pkg::ST_DONE;
			tgi_pkg::ST_DIV_START:
				state_d = tgi_pkg::ST_DIV_WAIT;
			tgi_pkg::ST_DIV_WAIT:
				if (div_done)
					state_d = tgi_pkg::ST_CORNER;
			tgi_pkg::ST_CORNER:
				if (cnt_q == 4'd9)
					state_d = tgi_pkg::ST_BL_MUL;
			tgi_pkg::ST_BL_MUL:
				state_d = tgi_pkg::ST_BL_ADD;
			tgi_pkg::ST_BL_ADD:
				state_d = (step_q == 3'd6) ? tgi_pkg::ST_DONE : tgi_pkg::ST_BL_MUL;
			tgi_pkg::ST_DONE:
				if (res_ready)
					state_d = tgi_pkg::ST_IDLE;
			default:
				state_d = tgi_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		g_we      = 1'b0;
		g_re      = 1'b0;
		g_addr    = addr_s1;
		bp_we     = 1'b0;
		bp_re     = 1'b0;
		bp_addr   = YW'(item_q.grid_y_index);
		mul_a     = MW'(item_q.coord_x);
		mul_b     = MW'({1'b0, cfg.x_step_inverse});
		div_start = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			tgi_pkg::ST_DISPATCH: begin
				g_addr = grid_addr(XW'(item_q.grid_x_index), YW'(item_q.grid_y_index),
					ZW'(item_q.grid_z_index));
				g_we   = (item_q.command == tgi_pkg::CMD_WRITE_SAMPLE) && wr_sample_ok;
				bp_we  = (item_q.command == tgi_pkg::CMD_WRITE_BREAK) && wr_break_ok;
			end
			tgi_pkg::ST_MULZ: begin
				mul_a = MW'(item_q.coord_z);
				mul_b = MW'({1'b0, cfg.z_step_inverse});
			end
			tgi_pkg::ST_SRCH_START: begin
				bp_re   = 1'b1;
				bp_addr = '0;
			end
			tgi_pkg::ST_SRCH: begin
				bp_re   = !y_lt && (j_q != YW'(GRID_Y - 1));
				bp_addr = YW'(j_q + 1'b1);
			end
			tgi_pkg::ST_DIV_START:
				div_start = 1'b1;
			tgi_pkg::ST_CORNER:
				g_re = (cnt_q >= 4'd1) && (cnt_q <= 4'd8);
			tgi_pkg::ST_BL_MUL: begin
				mul_a = MW'({b_sel[VW-1], b_sel} - {a_sel[VW-1], a_sel});
				mul_b = MW'({1'b0, w_sel});
			end
			tgi_pkg::ST_DONE:
				res_valid = 1'b1;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tgi_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			tgi_pkg::ST_IDLE:
				if (accept)
					item_q <= in_data;
			tgi_pkg::ST_DISPATCH: begin
				res_q.interpolated_value <= '0;
				case (item_q.command)
					tgi_pkg::CMD_WRITE_SAMPLE:
						res_q.status <= wr_sample_ok ? tgi_pkg::STATUS_WRITTEN
							: tgi_pkg::STATUS_OUTSIDE;
					tgi_pkg::CMD_WRITE_BREAK:
						res_q.status <= wr_break_ok ? tgi_pkg::STATUS_WRITTEN
							: tgi_pkg::STATUS_OUTSIDE;
					tgi_pkg::CMD_QUERY:
						res_q.status <= y_out ? tgi_pkg::STATUS_Y_BOUND
							: tgi_pkg::STATUS_OUTSIDE;
					default:
						res_q.status <= tgi_pkg::STATUS_OK;
				endcase
			end
			tgi_pkg::ST_MULX:
				prod_q <= product;
			tgi_pkg::ST_MULZ: begin
				i0_q   <= cell_idx[XW-1:0];
				xw_q   <= prod_q[31:16];
				prod_q <= product;
			end
			tgi_pkg::ST_CHKZ: begin
				k0_q <= cell_idx[ZW-1:0];
				zw_q <= prod_q[31:16];
			end
			tgi_pkg::ST_SRCH_START:
				j_q <= '0;
			tgi_pkg::ST_SRCH:
				if (y_lt) begin
					y1_q <= bp_rdata;
					j_q  <= j_q - 1'b1;
				end else begin
					y0_q <= bp_rdata;
					j_q  <= j_q + 1'b1;
				end
			tgi_pkg::ST_DIV_WAIT: begin
				yw_q  <= div_quo;
				cnt_q <= '0;
			end
			tgi_pkg::ST_CORNER: begin
				if (cnt_q < 4'd8)
					addr_s1 <= grid_addr(XW'(i0_q + corner_n[0]), YW'(j_q + corner_n[2]),
						ZW'(k0_q + corner_n[1]));
				if (cnt_q >= 4'd2)
					corner_q[corner_w] <= g_rdata;
				cnt_q  <= cnt_q + 1'b1;
				step_q <= '0;
			end
			tgi_pkg::ST_BL_MUL: begin
				prod_q <= product;
				a_q    <= a_sel;
			end
			tgi_pkg::ST_BL_ADD: begin
				blend_q[step_q] <= blend_sum[VW-1:0];
				step_q <= step_q + 1'b1;
				if (step_q == 3'd6) begin
					res_q.interpolated_value <= blend_sum[VW-1:0];
					res_q.status <= tgi_pkg::STATUS_OK;
				end
			end
			default: begin
			end
		endcase
	end

	assign res_data = res_q;
endmodule
`default_nettype wire

### design/trilinear_grid_interpolator.sv
// writes and unused commands go straight to the output register; a query in range
// passes through a breakpoint search, a divide, the corner memory reads and a blend
// throughput: one item at a time; the next item is taken once the result moves on
// reset returns config registers to defaults; sample and breakpoint memories stay unset
// depends on tgi_pkg and tgi_core
`default_nettype none
module trilinear_grid_interpolator #(
	parameter int GRID_X = tgi_pkg::GRID_X_DEF,
	parameter int GRID_Y = tgi_pkg::GRID_Y_DEF,
	parameter int GRID_Z = tgi_pkg::GRID_Z_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire tgi_pkg::in_item_t                 in_data,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output tgi_pkg::out_item_t                     out_data,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [tgi_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [tgi_pkg::VAL_W-1:0]         cfg_data
);
	tgi_pkg::cfg_t      cfg_q;
	tgi_pkg::out_item_t res_data;
	tgi_pkg::out_item_t out_data_q;
	logic               res_valid;
	logic               res_ready;
	logic               out_valid_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.x_step_inverse <= tgi_pkg::STEP_INV_RESET;
			cfg_q.z_step_inverse <= tgi_pkg::STEP_INV_RESET;
			cfg_q.y_bound_check  <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tgi_pkg::CFG_X_STEP_INV: cfg_q.x_step_inverse <= cfg_data;
				tgi_pkg::CFG_Z_STEP_INV: cfg_q.z_step_inverse <= cfg_data;
				tgi_pkg::CFG_Y_CHECK:    cfg_q.y_bound_check  <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	tgi_core #(
		.GRID_X (GRID_X),
		.GRID_Y (GRID_Y),
		.GRID_Z (GRID_Z)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid)
			out_data_q <= res_data;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
endmodule
`default_nettype wire

### design/tgi_checker.sv
// tgi_port_checker: port-level assertions for the trilinear grid interpolator
// depends on tgi_pkg; bound to trilinear_grid_interpolator
`default_nettype none
module tgi_port_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          in_valid,
	input wire logic                          in_stall,
	input wire tgi_pkg::in_item_t             in_data,
	input wire logic                          out_valid,
	input wire logic                          out_stall,
	input wire tgi_pkg::out_item_t            out_data,
	input wire logic                          cfg_valid,
	input wire logic                          cfg_ready,
	input wire logic [tgi_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [tgi_pkg::VAL_W-1:0]     cfg_data
);
	logic unused_ok;
	assign unused_ok = ^{in_data, cfg_valid, cfg_ready, cfg_index, cfg_data};

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("stalled output changed");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status != tgi_pkg::STATUS_OK) |->
			out_data.interpolated_value == '0)
		else $error("nonzero value with non-ok status");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second transfer taken while busy");
endmodule

bind trilinear_grid_interpolator tgi_port_checker u_tgi_port_checker (.*);
`default_nettype wire
